FILE: rtl/cht_pkg.sv
// Shared constants, payload types and status codes for the chained hash table.
package cht_pkg;

    localparam int BUCKETS      = 100;
    localparam int POOL_ENTRIES = 256;

    localparam int KEY_W  = 31;
    localparam int VAL_W  = 64;
    localparam int STAT_W = 2;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int PTR_W = $clog2(POOL_ENTRIES);
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

    // remainder unit: quotient = (key * RECIP) >> RECIP_SHIFT, exact for every KEY_W-bit key
    localparam int RECIP_SHIFT = KEY_W + BKT_W;
    localparam int RECIP_W     = KEY_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
    localparam int QUO_W     = KEY_W - BKT_W + 1;
    localparam int MOD_STEPS = 2;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_POOL_FULL = 2'd3;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
    } rsp_t;

    typedef struct packed {
        logic             vld;
        logic [PTR_W-1:0] ptr;
    } head_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             nxt_vld;
        logic [PTR_W-1:0] nxt;
    } entry_t;

endpackage

FILE: rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/cht_mod.sv
// Key-modulo-bucket-count unit: reciprocal multiply, then subtract back.
module cht_mod import cht_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             ready,
    output logic [BKT_W-1:0] bucket
);

    localparam int PROD_W = KEY_W + RECIP_W;

    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     key_next;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_next;
    logic [BKT_W-1:0]     rem_reg;
    logic [BKT_W-1:0]     rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;
    logic [PROD_W-1:0]    prod;
    logic [BKT_W-1:0]     back;

    // quotient step, then remainder step; the remainder fits in BKT_W bits,
    // so only the low bits of key - quotient * BUCKETS are needed
    always_comb
    begin
        prod = PROD_W'(key_reg) * PROD_W'(RECIP);
        back = key_reg[BKT_W-1:0] - quo_reg[BKT_W-1:0] * BKT_W'(BUCKETS);

        key_next = key_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            key_next = key;
            cnt_next = MOD_CNT_W'(MOD_STEPS);
        end
        else if (cnt_reg == MOD_CNT_W'(MOD_STEPS))
        begin
            quo_next = prod[RECIP_SHIFT +: QUO_W];
            cnt_next = cnt_reg - 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = back;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign ready  = (cnt_reg == '0);
    assign bucket = rem_reg;

endmodule

FILE: rtl/chained_hash_table_core.sv
// Separate-chaining hash table: insert key/value pairs or look keys up, one transfer at a time.
//
// One request transfer on req_* yields exactly one response transfer on rsp_*. The bucket is
// key mod BUCKETS, worked out by a remainder unit that multiplies the key by a fixed
// reciprocal of BUCKETS and then subtracts the quotient's multiple back off, before the
// bucket head can be read. An insert then writes the new entry and the bucket head (a full
// pool skips the head read); a lookup walks the chain, one read of the entry memory followed
// by a key compare per entry visited. No new request is taken until the result is loaded
// into the output register. Inserts link the new entry at the
// head of its chain, so the newest copy of a duplicate key is found first; once all
// POOL_ENTRIES entries are taken, inserts return status pool-full and change nothing.
// After reset the block clears every one of the BUCKETS bucket-head entries (100 at the
// default) with req_stall high before the first request is taken. A finished response sits
// in an output register, so the next request is taken while rsp_stall holds the last one.
module chained_hash_table_core import cht_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,  // bucket-head sweep after reset
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,  // remainder unit busy
        S_HEAD  = 6'b001000,  // bucket head read data valid
        S_ENT   = 6'b010000,  // entry read data valid, chain walk
        S_DONE  = 6'b100000   // result ready, wait for output register
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [BKT_W-1:0] clr_cnt_reg;
    logic [BKT_W-1:0] clr_cnt_next;
    logic [CNT_W-1:0] used_cnt_reg;
    logic [CNT_W-1:0] used_cnt_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    // payload
    req_t item_reg;
    req_t item_next;
    rsp_t res_reg;
    rsp_t res_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    logic accept;
    logic load_rsp;
    logic pool_full;

    // remainder unit
    logic             mod_start;
    logic             mod_ready;
    logic [BKT_W-1:0] bucket;

    // bucket-head memory
    logic             head_wr_en;
    logic [BKT_W-1:0] head_wr_addr;
    head_t            head_wr_data;
    logic             head_rd_en;
    head_t            head_rd_data;

    // entry pool memory
    logic             ent_wr_en;
    logic [PTR_W-1:0] ent_wr_addr;
    entry_t           ent_wr_data;
    logic             ent_rd_en;
    logic [PTR_W-1:0] ent_rd_addr;
    entry_t           ent_rd_data;

    cht_mod u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .key    (req_data.key),
        .ready  (mod_ready),
        .bucket (bucket)
    );

    cht_ram #(
        .WIDTH ($bits(head_t)),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (head_wr_en),
        .wr_addr (head_wr_addr),
        .wr_data (head_wr_data),
        .rd_en   (head_rd_en),
        .rd_addr (bucket),
        .rd_data (head_rd_data)
    );

    cht_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (POOL_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign pool_full = (used_cnt_reg == CNT_W'(POOL_ENTRIES));

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        used_cnt_next = used_cnt_reg;
        item_next     = accept ? req_data : item_reg;
        res_next      = res_reg;
        load_rsp      = 1'b0;
        mod_start     = 1'b0;
        head_wr_en    = 1'b0;
        head_wr_addr  = bucket;
        head_wr_data  = '0;
        head_rd_en    = 1'b0;
        ent_wr_en     = 1'b0;
        ent_wr_addr   = used_cnt_reg[PTR_W-1:0];
        ent_wr_data   = '0;
        ent_rd_en     = 1'b0;
        ent_rd_addr   = ent_rd_data.nxt;

        case (state_reg)
            S_CLEAR:
            begin
                head_wr_en   = 1'b1;
                head_wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_ready)
                begin
                    if (item_reg.action == ACT_INSERT && pool_full)
                    begin
                        res_next   = '{status: ST_POOL_FULL, found_value: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        head_rd_en = 1'b1;
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                if (item_reg.action == ACT_INSERT)
                begin
                    // new entry points at the old head, then becomes the head
                    ent_wr_en     = 1'b1;
                    ent_wr_data   = '{key: item_reg.key, value: item_reg.value,
                                      nxt_vld: head_rd_data.vld, nxt: head_rd_data.ptr};
                    head_wr_en    = 1'b1;
                    head_wr_data  = '{vld: 1'b1, ptr: used_cnt_reg[PTR_W-1:0]};
                    used_cnt_next = used_cnt_reg + 1'b1;
                    res_next      = '{status: ST_INSERTED, found_value: '0};
                    state_next    = S_DONE;
                end
                else if (head_rd_data.vld)
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = head_rd_data.ptr;
                    state_next  = S_ENT;
                end
                else
                begin
                    res_next   = '{status: ST_NOT_FOUND, found_value: '0};
                    state_next = S_DONE;
                end
            end
            S_ENT:
            begin
                if (ent_rd_data.key == item_reg.key)
                begin
                    res_next   = '{status: ST_FOUND, found_value: ent_rd_data.value};
                    state_next = S_DONE;
                end
                else if (ent_rd_data.nxt_vld)
                begin
                    ent_rd_en = 1'b1;
                end
                else
                begin
                    res_next   = '{status: ST_NOT_FOUND, found_value: '0};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // output register: load a new result, or drop the old one once transferred
    always_comb
    begin
        rsp_next       = load_rsp ? res_reg : rsp_reg;
        rsp_valid_next = load_rsp || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            used_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // pool count never runs past the pool size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_cnt_reg <= CNT_W'(POOL_ENTRIES))
        else $error("used count past pool size");

    // only a found result carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_FOUND |-> rsp_data.found_value == '0)
        else $error("nonzero value on a result other than found");

    // pool-full is reported only when every entry is taken
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_POOL_FULL |-> pool_full)
        else $error("pool-full result with free entries");

    // an accepted request starts the remainder unit
    a_start_mod: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_MOD && !mod_ready)
        else $error("request taken without starting the bucket computation");

endmodule

FILE: sim/chained_hash_table_core_tb.sv
// Self-checking testbench for the chained hash table core: directed and random insert/lookup traffic.
module chained_hash_table_core_tb;
    import cht_pkg::*;

    // No-transfer watchdog. The worst legal quiet stretch is the reset sweep
    // over all BUCKETS heads or one lookup walking a full pool-long chain,
    // plus random receiver stalls. This limit is many times that.
    localparam int STALL_LIMIT  = 5000;
    // Quiet cycles after the last response, so a stray extra transfer is caught.
    localparam int DRAIN_CYCLES = POOL_ENTRIES + 64;
    localparam int MAX_REPORTS  = 10;
    // Bucket that random keys pile into, so that long chains get walked.
    localparam int HOT_BUCKET   = 37;

    localparam logic [KEY_W-1:0] KEY_MAX  = '1;
    localparam logic [VAL_W-1:0] VAL_ONES = '1;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    chained_hash_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the table. Chain links use -1 as the end-of-chain
    // marker, so only entries that were linked are ever read back.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] shadow_key  [POOL_ENTRIES];
    logic [VAL_W-1:0] shadow_val  [POOL_ENTRIES];
    int               shadow_next [POOL_ENTRIES];
    int               shadow_head [BUCKETS];
    int               shadow_used = 0;

    logic [KEY_W-1:0] stored_keys [$];     // keys inserted so far, for lookup hits
    rsp_t             pending_replies [$]; // responses still owed by the core, oldest first

    // Handshake pacing, changed between traffic phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches  = 0;
    int idle_cycles = 0;
    int n_requests  = 0;
    int n_inserted  = 0;
    int n_hits      = 0;
    int n_misses    = 0;
    int n_refused   = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        foreach (shadow_head[b])
        begin
            shadow_head[b] = -1;
        end
    end

    // Apply one request to the shadow table and return the response it owes.
    function automatic rsp_t predict_hash_op(req_t r);
        int   bkt;
        int   cur;
        rsp_t rsp;
        bkt = int'(r.key % BUCKETS);
        rsp.status      = ST_NOT_FOUND;
        rsp.found_value = '0;
        n_requests++;
        if (r.action == ACT_INSERT)
        begin
            if (shadow_used >= POOL_ENTRIES)
            begin
                // pool exhausted: nothing changes
                rsp.status = ST_POOL_FULL;
                n_refused++;
            end
            else
            begin
                // new entry goes to the head of its chain
                shadow_key[shadow_used]  = r.key;
                shadow_val[shadow_used]  = r.value;
                shadow_next[shadow_used] = shadow_head[bkt];
                shadow_head[bkt]         = shadow_used;
                shadow_used++;
                stored_keys.push_back(r.key);
                rsp.status = ST_INSERTED;
                n_inserted++;
            end
        end
        else
        begin
            // walk from the head; newest duplicate wins
            cur = shadow_head[bkt];
            while (cur >= 0)
            begin
                if (shadow_key[cur] == r.key)
                begin
                    rsp.status      = ST_FOUND;
                    rsp.found_value = shadow_val[cur];
                    break;
                end
                cur = shadow_next[cur];
            end
            if (rsp.status == ST_FOUND)
                n_hits++;
            else
                n_misses++;
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Request side. valid stays high from one transfer to the next unless
    // a random gap is drawn; the payload holds while stalled.
    // ------------------------------------------------------------------
    task automatic send_req(input logic act, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
        int   gap;
        req_t item;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        item.action = act;
        item.key    = k;
        item.value  = v;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_replies.push_back(predict_hash_op(item));
    endtask

    // Hold off new requests until every owed response has come back.
    // Always spends at least one clock, so valid is never dropped and
    // raised in the same step.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Key mix: stored keys for hits, a narrow range and one hot bucket for
    // collisions, full-width keys so every bit toggles, and the corners.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40 && stored_keys.size() > 0)
            return stored_keys[$urandom_range(stored_keys.size() - 1)];
        if (sel < 62)
            return KEY_W'($urandom_range(999));
        if (sel < 78)
            return KEY_W'($urandom_range(40) * BUCKETS + HOT_BUCKET);
        if (sel < 94)
            return KEY_W'($urandom);
        case ($urandom_range(3))
            0:       return '0;
            1:       return KEY_MAX;
            2:       return KEY_W'(BUCKETS - 1);
            default: return KEY_W'(BUCKETS);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return VAL_ONES;
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Response side: random stall, then compare each transfer against the
    // oldest owed response.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected status %0d value %h, got status %0d value %h",
                     $realtime, what, want.status, want.found_value,
                     got.status, got.found_value);
    endtask

    always @(posedge clk)
    begin : check_replies
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                want = '0;
                flag_mismatch("response with none outstanding", want, rsp_data);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_data.status !== want.status)
                    flag_mismatch("status mismatch", want, rsp_data);
                else if (rsp_data.found_value !== want.found_value)
                    flag_mismatch("found_value mismatch", want, rsp_data);
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d responses owed",
                         STALL_LIMIT, pending_replies.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners: empty-table misses, extreme keys and values, collisions in
    // bucket 0, a miss at the end of a live chain, duplicate keys, the last
    // bucket, alternating key bits, and a lookup carrying a nonzero value.
    task automatic test_directed();
        send_req(ACT_LOOKUP, '0, '0);
        send_req(ACT_LOOKUP, KEY_MAX, VAL_ONES);
        send_req(ACT_INSERT, '0, '0);
        send_req(ACT_INSERT, KEY_MAX, VAL_ONES);
        send_req(ACT_INSERT, KEY_W'(BUCKETS), 64'h0123_4567_89AB_CDEF);
        send_req(ACT_LOOKUP, '0, 64'hDEAD_BEEF_DEAD_BEEF);
        send_req(ACT_LOOKUP, KEY_W'(BUCKETS), '0);
        send_req(ACT_LOOKUP, KEY_W'(2 * BUCKETS), '0);
        send_req(ACT_LOOKUP, KEY_MAX, '0);
        send_req(ACT_INSERT, KEY_W'(BUCKETS), 64'hFEDC_BA98_7654_3210);
        send_req(ACT_LOOKUP, KEY_W'(BUCKETS), '0);
        send_req(ACT_INSERT, KEY_W'(BUCKETS - 1), 64'hA5A5_A5A5_5A5A_5A5A);
        send_req(ACT_LOOKUP, KEY_W'(BUCKETS - 1), '0);
        send_req(ACT_LOOKUP, KEY_W'(2 * BUCKETS - 1), '0);
        send_req(ACT_INSERT, KEY_W'(1), 64'h8000_0000_0000_0001);
        send_req(ACT_LOOKUP, KEY_W'(1), '0);
        send_req(ACT_INSERT, 31'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(ACT_INSERT, 31'h5555_5555, 64'h5555_5555_5555_5555);
        send_req(ACT_LOOKUP, 31'h2AAA_AAAA, '0);
        send_req(ACT_LOOKUP, 31'h5555_5555, '0);
        send_req(ACT_LOOKUP, 31'h7FFF_FF00, '0);
        wait_drained();
    endtask

    // Random mix; drains once halfway so the core sees a fully idle input.
    task automatic test_random_traffic(input int count, input int insert_pct);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            send_req(($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_LOOKUP,
                     pick_key(), pick_value());
        end
        wait_drained();
    endtask

    // Use up whatever is left of the pool, then check that further inserts
    // are refused while lookups of old and refused keys still behave.
    task automatic test_pool_full();
        logic [KEY_W-1:0] k;
        while (shadow_used < POOL_ENTRIES)
            send_req(ACT_INSERT, pick_key(), pick_value());
        for (int i = 0; i < 6; i++)
        begin
            k = KEY_W'($urandom);
            send_req(ACT_INSERT, k, pick_value());
            send_req(ACT_LOOKUP, k, '0);
            send_req(ACT_LOOKUP, pick_key(), '0);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver stalling heavily
        send_idle_pct  = 22;
        recv_stall_pct = 80;
        test_directed();
        test_random_traffic(180, 60);

        // sender sparse, receiver mostly ready
        send_idle_pct  = 80;
        recv_stall_pct = 22;
        test_random_traffic(180, 60);
        test_pool_full();

        // back to back on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(150, 30);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d inserts, %0d refused on a full pool, %0d hits, %0d misses.",
                 n_requests, n_inserted, n_refused, n_hits, n_misses);
        $display("Pacing: sender-heavy, receiver-heavy and no-idle phases; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
